>>> hw/rtl/snfp_pkg.sv
// shared types, constants and tanh table for the sparse network forward pass unit
package snfp_pkg;

  // default sizes
  localparam int MAX_CONNECTIONS_DEF = 64;
  localparam int NUM_NEURONS_DEF     = 32;
  localparam int FRAC_BITS_DEF       = 12;

  // field widths of the stream words
  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 6;
  localparam int NID_W      = 5;
  localparam int VAL_W      = 16;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 24;

  // field positions in the input word
  localparam int SLOT_LSB   = 0;
  localparam int SRC_LSB    = 6;
  localparam int DST_LSB    = 11;
  localparam int WEIGHT_LSB = 16;
  localparam int NVAL_LSB   = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int ACT_W      = 7;
  localparam int FIRST_W    = 6;
  localparam logic [ACT_W-1:0]   ACT_RESET   = 7'd0;
  localparam logic [FIRST_W-1:0] FIRST_RESET = 6'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CONNECTIONS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ACTIVATED_NEURON = 2'd1;

  // input word kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CONN   = 2'd0,
    KIND_NEURON = 2'd1,
    KIND_RUN    = 2'd2
  } kind_t;

  // source of a neuron store write
  typedef enum logic [1:0] {
    NWR_LOAD = 2'd0,
    NWR_ACC  = 2'd1,
    NWR_TANH = 2'd2
  } nwr_sel_t;

  // one connection table entry
  typedef struct packed {
    logic [NID_W-1:0]        src;
    logic [NID_W-1:0]        dst;
    logic signed [VAL_W-1:0] w;
  } conn_entry_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     tab_we;
    logic     tab_rd;
    logic     nst_we;
    nwr_sel_t nst_wsel;
    logic     nrd_en;
    logic     nrd_conn;
    logic     prod_en;
    logic     tanh_en;
    logic     ccnt_clr;
    logic     ccnt_inc;
    logic     ncnt_clr;
    logic     ncnt_first;
    logic     ncnt_inc;
  } snfp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic conn_none;
    logic conn_last;
    logic act_none;
    logic n_last;
  } snfp_sts_t;

  // tanh knots, round(65536*tanh(k/4))
  localparam logic [15:0] TANH_TOP = 16'd65492;

  function automatic logic [15:0] tanh_lut(input logic [4:0] k);
    logic [15:0] r;
    case (k)
      5'd0:    r = 16'd0;
      5'd1:    r = 16'd16051;
      5'd2:    r = 16'd30285;
      5'd3:    r = 16'd41625;
      5'd4:    r = 16'd49912;
      5'd5:    r = 16'd55593;
      5'd6:    r = 16'd59320;
      5'd7:    r = 16'd61694;
      5'd8:    r = 16'd63179;
      5'd9:    r = 16'd64096;
      5'd10:   r = 16'd64659;
      5'd11:   r = 16'd65003;
      5'd12:   r = 16'd65212;
      5'd13:   r = 16'd65339;
      5'd14:   r = 16'd65417;
      5'd15:   r = 16'd65464;
      default: r = TANH_TOP;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/snfp_datapath.sv
// datapath: connection table, neuron store, multiply-accumulate, tanh and counters
module snfp_datapath #(
  parameter int MAX_CONNECTIONS = snfp_pkg::MAX_CONNECTIONS_DEF,
  parameter int NUM_NEURONS     = snfp_pkg::NUM_NEURONS_DEF,
  parameter int FRAC_BITS       = snfp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  snfp_pkg::snfp_cmd_t                 cmd,
  output snfp_pkg::snfp_sts_t                 sts,
  input  logic [snfp_pkg::S_TDATA_W-1:0]      in_word,
  input  logic                                cfg_we,
  input  logic [snfp_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [snfp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [snfp_pkg::NID_W-1:0]          out_index,
  output logic signed [snfp_pkg::VAL_W-1:0]   out_value
);

  localparam int TA_W  = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_CONNECTIONS + 1);
  localparam int NA_W  = $clog2(NUM_NEURONS);
  localparam int NC_W  = $clog2(NUM_NEURONS + 1);
  localparam int SEG   = FRAC_BITS - 2;
  localparam int DP_W  = 16 + SEG;
  localparam logic [32:0] HALF     = 33'(1) << (FRAC_BITS - 1);
  localparam logic [16:0] TANH_RND = 17'(1) << (15 - FRAC_BITS);

  // input word fields
  logic [snfp_pkg::SLOT_W-1:0]        in_slot;
  logic [snfp_pkg::NID_W-1:0]         in_src;
  logic [snfp_pkg::NID_W-1:0]         in_dst;
  logic signed [snfp_pkg::VAL_W-1:0]  in_w;
  logic signed [snfp_pkg::VAL_W-1:0]  in_nval;

  assign in_slot = in_word[snfp_pkg::SLOT_LSB +: snfp_pkg::SLOT_W];
  assign in_src  = in_word[snfp_pkg::SRC_LSB +: snfp_pkg::NID_W];
  assign in_dst  = in_word[snfp_pkg::DST_LSB +: snfp_pkg::NID_W];
  assign in_w    = in_word[snfp_pkg::WEIGHT_LSB +: snfp_pkg::VAL_W];
  assign in_nval = in_word[snfp_pkg::NVAL_LSB +: snfp_pkg::VAL_W];

  // configuration registers
  logic [snfp_pkg::ACT_W-1:0]   act_cfg;
  logic [snfp_pkg::FIRST_W-1:0] first_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_cfg   <= snfp_pkg::ACT_RESET;
      first_cfg <= snfp_pkg::FIRST_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == snfp_pkg::REG_ACTIVE_CONNECTIONS) begin
        act_cfg <= cfg_wdata;
      end else if (cfg_idx == snfp_pkg::REG_FIRST_ACTIVATED_NEURON) begin
        first_cfg <= cfg_wdata[snfp_pkg::FIRST_W-1:0];
      end
    end
  end

  // connection count clamped to the table size
  logic [CNT_W-1:0] n_eff;
  always_comb begin
    if (int'(act_cfg) > MAX_CONNECTIONS) begin
      n_eff = CNT_W'(MAX_CONNECTIONS);
    end else begin
      n_eff = CNT_W'(act_cfg);
    end
  end

  // connection and neuron counters
  logic [CNT_W-1:0] ccnt;
  logic [NC_W-1:0]  ncnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      ccnt <= '0;
      ncnt <= '0;
    end else begin
      if (cmd.ccnt_clr) begin
        ccnt <= '0;
      end else if (cmd.ccnt_inc) begin
        ccnt <= ccnt + CNT_W'(1);
      end
      if (cmd.ncnt_clr) begin
        ncnt <= '0;
      end else if (cmd.ncnt_first) begin
        ncnt <= NC_W'(first_cfg);
      end else if (cmd.ncnt_inc) begin
        ncnt <= ncnt + NC_W'(1);
      end
    end
  end

  assign sts.conn_none = (n_eff == '0);
  assign sts.conn_last = ((CNT_W+1)'(ccnt) + (CNT_W+1)'(1)) == (CNT_W+1)'(n_eff);
  assign sts.act_none  = (int'(first_cfg) >= NUM_NEURONS);
  assign sts.n_last    = (ncnt == NC_W'(NUM_NEURONS - 1));

  // connection table, contents undefined until written
  snfp_pkg::conn_entry_t ctab [MAX_CONNECTIONS];
  snfp_pkg::conn_entry_t entry_q;

  always_ff @(posedge clk) begin
    if (cmd.tab_we && (int'(in_slot) < MAX_CONNECTIONS)) begin
      ctab[TA_W'(in_slot)] <= '{src: in_src, dst: in_dst, w: in_w};
    end
    if (cmd.tab_rd) begin
      entry_q <= ctab[ccnt[TA_W-1:0]];
    end
  end

  // neuron store with per-entry valid bits, unwritten entries read as zero
  logic signed [snfp_pkg::VAL_W-1:0] nst [NUM_NEURONS];
  logic [NUM_NEURONS-1:0]            nvld;
  logic [NA_W-1:0]                   ra_addr;
  logic [NA_W-1:0]                   rb_addr;
  logic signed [snfp_pkg::VAL_W-1:0] a_q;
  logic signed [snfp_pkg::VAL_W-1:0] b_q;
  logic                              a_vld;
  logic                              b_vld;
  logic signed [snfp_pkg::VAL_W-1:0] a_val;
  logic signed [snfp_pkg::VAL_W-1:0] b_val;
  logic [NA_W-1:0]                   w_addr;
  logic signed [snfp_pkg::VAL_W-1:0] w_data;
  logic                              w_en;

  assign ra_addr = cmd.nrd_conn ? NA_W'(entry_q.src) : ncnt[NA_W-1:0];
  assign rb_addr = NA_W'(entry_q.dst);

  always_ff @(posedge clk) begin
    if (cmd.nrd_en) begin
      a_q <= nst[ra_addr];
      b_q <= nst[rb_addr];
    end
    if (w_en) begin
      nst[w_addr] <= w_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nvld  <= '0;
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      if (cmd.nrd_en) begin
        a_vld <= nvld[ra_addr];
        b_vld <= nvld[rb_addr];
      end
      if (w_en) begin
        nvld[w_addr] <= 1'b1;
      end
    end
  end

  assign a_val = a_vld ? a_q : '0;
  assign b_val = b_vld ? b_q : '0;

  // product of source value and weight
  logic signed [31:0] prod_q;
  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod_q <= a_val * entry_q.w;
    end
  end

  // round half up, add into destination, saturate
  logic signed [32:0]                pr;
  logic signed [32:0]                term;
  logic signed [33:0]                sum;
  logic signed [snfp_pkg::VAL_W-1:0] acc_res;
  logic                              skip;

  always_comb begin
    pr   = $signed({prod_q[31], prod_q}) + $signed(HALF);
    term = pr >>> FRAC_BITS;
    sum  = $signed({term[32], term}) + $signed({{18{b_val[15]}}, b_val});
    if (sum > 34'sd32767) begin
      acc_res = 16'sh7fff;
    end else if (sum < -34'sd32768) begin
      acc_res = 16'sh8000;
    end else begin
      acc_res = sum[15:0];
    end
  end

  assign skip = (int'(entry_q.src) >= NUM_NEURONS) || (int'(entry_q.dst) >= NUM_NEURONS);

  // tanh, first half: magnitude, segment lookup, slope times fraction
  logic [16:0]     mag;
  logic [16:0]     seg_i;
  logic [SEG-1:0]  frac;
  logic [15:0]     base;
  logic [15:0]     slope;
  logic            neg_q;
  logic            big_q;
  logic [15:0]     base_q;
  logic [DP_W-1:0] dprod_q;

  always_comb begin
    mag   = a_val[15] ? 17'(-$signed({a_val[15], a_val})) : 17'({a_val[15], a_val});
    seg_i = mag >> SEG;
    frac  = mag[SEG-1:0];
    base  = snfp_pkg::tanh_lut({1'b0, seg_i[3:0]});
    slope = snfp_pkg::tanh_lut(5'({1'b0, seg_i[3:0]}) + 5'd1) - base;
  end

  always_ff @(posedge clk) begin
    if (cmd.tanh_en) begin
      neg_q   <= a_val[15];
      big_q   <= (seg_i >= 17'd16);
      base_q  <= base;
      dprod_q <= DP_W'(slope) * DP_W'(frac);
    end
  end

  // tanh, second half: interpolate, scale back to the value format, restore sign
  logic [16:0]                       y;
  logic [16:0]                       m;
  logic signed [snfp_pkg::VAL_W-1:0] tanh_res;

  always_comb begin
    y        = big_q ? 17'(snfp_pkg::TANH_TOP) : 17'(base_q) + 17'(dprod_q >> SEG);
    m        = (y + TANH_RND) >> (16 - FRAC_BITS);
    tanh_res = neg_q ? 16'(-m) : 16'(m);
  end

  // neuron store write select
  always_comb begin
    case (cmd.nst_wsel)
      snfp_pkg::NWR_LOAD: begin
        w_addr = NA_W'(in_slot);
        w_data = in_nval;
        w_en   = cmd.nst_we && (int'(in_slot) < NUM_NEURONS);
      end
      snfp_pkg::NWR_ACC: begin
        w_addr = NA_W'(entry_q.dst);
        w_data = acc_res;
        w_en   = cmd.nst_we && !skip;
      end
      snfp_pkg::NWR_TANH: begin
        w_addr = ncnt[NA_W-1:0];
        w_data = tanh_res;
        w_en   = cmd.nst_we;
      end
      default: begin
        w_addr = '0;
        w_data = '0;
        w_en   = 1'b0;
      end
    endcase
  end

  // emitted word comes straight from the registered read
  assign out_index = snfp_pkg::NID_W'(ncnt);
  assign out_value = a_val;

endmodule

>>> hw/rtl/snfp_ctrl.sv
// controller: sequences loads, the connection walk, the tanh sweep and the emit phase
module snfp_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic [snfp_pkg::KIND_W-1:0]     s_kind,
  output logic                            s_tready,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output snfp_pkg::snfp_cmd_t             cmd,
  input  snfp_pkg::snfp_sts_t             sts
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_RD,
    ST_C_NRD,
    ST_C_MUL,
    ST_C_ACC,
    ST_T_RD,
    ST_T_CALC,
    ST_T_WR,
    ST_E_RD,
    ST_E_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_acc;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_E_OUT);
  assign in_acc   = s_tvalid && s_tready;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.nst_wsel = snfp_pkg::NWR_LOAD;
        if (in_acc) begin
          unique case (snfp_pkg::kind_t'(s_kind))
            snfp_pkg::KIND_CONN:   cmd.tab_we = 1'b1;
            snfp_pkg::KIND_NEURON: cmd.nst_we = 1'b1;
            snfp_pkg::KIND_RUN: begin
              cmd.ccnt_clr = 1'b1;
              if (!sts.conn_none) begin
                state_next = ST_C_RD;
              end else if (sts.act_none) begin
                cmd.ncnt_clr = 1'b1;
                state_next   = ST_E_RD;
              end else begin
                cmd.ncnt_first = 1'b1;
                state_next     = ST_T_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_C_RD: begin
        cmd.tab_rd = 1'b1;
        state_next = ST_C_NRD;
      end
      ST_C_NRD: begin
        cmd.nrd_en   = 1'b1;
        cmd.nrd_conn = 1'b1;
        state_next   = ST_C_MUL;
      end
      ST_C_MUL: begin
        cmd.prod_en = 1'b1;
        state_next  = ST_C_ACC;
      end
      ST_C_ACC: begin
        cmd.nst_we   = 1'b1;
        cmd.nst_wsel = snfp_pkg::NWR_ACC;
        if (!sts.conn_last) begin
          cmd.ccnt_inc = 1'b1;
          state_next   = ST_C_RD;
        end else if (sts.act_none) begin
          cmd.ncnt_clr = 1'b1;
          state_next   = ST_E_RD;
        end else begin
          cmd.ncnt_first = 1'b1;
          state_next     = ST_T_RD;
        end
      end
      ST_T_RD: begin
        cmd.nrd_en = 1'b1;
        state_next = ST_T_CALC;
      end
      ST_T_CALC: begin
        cmd.tanh_en = 1'b1;
        state_next  = ST_T_WR;
      end
      ST_T_WR: begin
        cmd.nst_we   = 1'b1;
        cmd.nst_wsel = snfp_pkg::NWR_TANH;
        if (sts.n_last) begin
          cmd.ncnt_clr = 1'b1;
          state_next   = ST_E_RD;
        end else begin
          cmd.ncnt_inc = 1'b1;
          state_next   = ST_T_RD;
        end
      end
      ST_E_RD: begin
        cmd.nrd_en = 1'b1;
        state_next = ST_E_OUT;
      end
      ST_E_OUT: begin
        if (m_tready) begin
          if (sts.n_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.ncnt_inc = 1'b1;
            state_next   = ST_E_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/sparse_network_forward_pass_unit.sv
// Sparse network forward pass: a load word (connection entry or neuron value) is taken
// while the block is idle. A run word walks connection entries 0 to active_connections-1
// (capped at MAX_CONNECTIONS) through table read, neuron read, multiply, accumulate and
// write back through the single write port of the neuron store, then sweeps the activated
// neurons through read, tanh segment lookup and multiply, and write back, then emits
// NUM_NEURONS words, each read and then held until m_tready is high; s_tready is low
// for the whole run. The neuron store comes out of reset all zero through per-entry
// valid bits, so there is no clearing pass; connection entries must be written before a
// run uses them.
module sparse_network_forward_pass_unit #(
  parameter int MAX_CONNECTIONS = snfp_pkg::MAX_CONNECTIONS_DEF,
  parameter int NUM_NEURONS     = snfp_pkg::NUM_NEURONS_DEF,
  parameter int FRAC_BITS       = snfp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // slot[5:0], source_neuron[10:6], dest_neuron[15:11], weight[31:16], neuron_value[47:32]
  input  logic [snfp_pkg::S_TDATA_W-1:0]      s_tdata,
  // kind[1:0]
  input  logic [snfp_pkg::KIND_W-1:0]         s_tuser,
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // neuron_index[4:0], value[20:5], zero fill[23:21]
  output logic [snfp_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                m_tlast,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [snfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [snfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  snfp_pkg::snfp_cmd_t               cmd;
  snfp_pkg::snfp_sts_t               sts;
  logic [snfp_pkg::NID_W-1:0]        out_index;
  logic signed [snfp_pkg::VAL_W-1:0] out_value;

  assign cfg_ready = 1'b1;

  snfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_kind   (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  snfp_datapath #(
    .MAX_CONNECTIONS (MAX_CONNECTIONS),
    .NUM_NEURONS     (NUM_NEURONS),
    .FRAC_BITS       (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_index (out_index),
    .out_value (out_value)
  );

  // output word packing
  assign m_tdata = {3'b000, out_value, out_index};
  assign m_tlast = m_tvalid && sts.n_last;

  // input and output sides are never open at the same time
  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input ready while an output word is pending");

  // a run word closes the input until the run is over
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == snfp_pkg::KIND_RUN)) |=> !s_tready)
    else $error("input still ready after a run word");

  // the last emitted word returns the block to idle
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("block not idle after the last word of a run");

  // load words never start an output
  a_load_no_output: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser != snfp_pkg::KIND_RUN)) |=> s_tready)
    else $error("load word left the block busy");

endmodule
